// ===== rtl/clac_pkg.sv =====
// Card locker access controller: shared widths, codes and helper functions.
// No dependencies; used by the core and the port checker.
`timescale 1ns / 1ps

package clac_pkg;

    localparam int KIND_W  = 2;
    localparam int UID_W   = 56;
    localparam int LEN_W   = 3;
    localparam int EIDX_W  = 4;
    localparam int MASK_W  = 16;
    localparam int TICKS_W = 16;
    localparam int EVT_W   = 2;
    localparam int LIDX_W  = 4;

    localparam int LOCKERS_DEF   = 16;
    localparam int UID_BYTES_DEF = 7;

    localparam logic [TICKS_W-1:0] OPEN_TICKS_RST = 16'd3000;

    localparam logic [KIND_W-1:0] KIND_TICK  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_POLL  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_WRITE = 2'd2;

    localparam logic [EVT_W-1:0] EVT_NONE   = 2'd0;
    localparam logic [EVT_W-1:0] EVT_ARRIVE = 2'd1;
    localparam logic [EVT_W-1:0] EVT_REMOVE = 2'd2;

    // Mask covering the low n bytes of an identifier.
    function automatic logic [UID_W-1:0] byte_mask(input logic [3:0] n);
        logic [UID_W-1:0] m;
        m = '0;
        for (int b = 0; b < UID_W / 8; b++) begin
            if (4'(b) < n) begin
                m[b*8 +: 8] = 8'hFF;
            end
        end
        return m;
    endfunction

endpackage

// ===== rtl/clac_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps

module clac_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/card_locker_access_controller_core.sv =====
// Card locker access controller core: identifier table and countdowns in RAM,
// valid and relay bits in flops, scanned by a small sequencer.
// Depends on clac_pkg and clac_ram.
// Flow: table writes, unused kinds and polls without a new card go from idle straight
//   to done; an arriving card or a tick first scans the entries (one RAM read per entry).
// One item at a time: the next item is taken once the result is queued.
// Reset (synchronous, active low): clears valid bits, relays, presence and the
//   output valid flag; open_ticks returns to 3000. RAM contents are not cleared.
`timescale 1ns / 1ps

module card_locker_access_controller_core #(
    parameter int LOCKERS   = clac_pkg::LOCKERS_DEF,
    parameter int UID_BYTES = clac_pkg::UID_BYTES_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,

    input  logic                         i_cfg_we,
    input  logic [clac_pkg::TICKS_W-1:0] i_cfg_wdata,

    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [clac_pkg::KIND_W-1:0]  i_kind,
    input  logic                         i_card_present,
    input  logic [clac_pkg::UID_W-1:0]   i_card_uid,
    input  logic [clac_pkg::LEN_W-1:0]   i_uid_length,
    input  logic [clac_pkg::EIDX_W-1:0]  i_entry_index,
    input  logic [clac_pkg::UID_W-1:0]   i_entry_uid,

    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [clac_pkg::MASK_W-1:0]  o_relay_mask,
    output logic [clac_pkg::EVT_W-1:0]   o_card_event,
    output logic                         o_matched,
    output logic [clac_pkg::LIDX_W-1:0]  o_locker_index
);

    localparam int IW = (LOCKERS > 1) ? $clog2(LOCKERS) : 1;
    localparam int CW = $clog2(LOCKERS + 1);

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_TICK, S_DONE} t_state;

    t_state                         r_state, n_state;
    logic [LOCKERS-1:0]             r_valid, n_valid;
    logic [LOCKERS-1:0]             r_relay, n_relay;
    logic                           r_was, n_was;
    logic [clac_pkg::TICKS_W-1:0]   r_open_ticks, n_open_ticks;
    logic [CW-1:0]                  r_rd_idx, n_rd_idx;
    logic                           r_cmp_vld, n_cmp_vld;
    logic [IW-1:0]                  r_cmp_idx, n_cmp_idx;
    logic [clac_pkg::UID_W-1:0]     r_uid, n_uid;
    logic [clac_pkg::UID_W-1:0]     r_mask, n_mask;
    logic [clac_pkg::EVT_W-1:0]     r_evt, n_evt;
    logic                           r_hit, n_hit;
    logic [IW-1:0]                  r_hit_idx, n_hit_idx;

    logic                           r_out_vld, n_out_vld;
    logic [clac_pkg::MASK_W-1:0]    r_out_mask, n_out_mask;
    logic [clac_pkg::EVT_W-1:0]     r_out_evt, n_out_evt;
    logic                           r_out_hit, n_out_hit;
    logic [clac_pkg::LIDX_W-1:0]    r_out_idx, n_out_idx;

    logic                           tbl_we;
    logic [IW-1:0]                  tbl_waddr;
    logic [clac_pkg::UID_W-1:0]     tbl_wdata;
    logic [clac_pkg::UID_W-1:0]     tbl_rdata;
    logic                           cnt_we;
    logic [IW-1:0]                  cnt_waddr;
    logic [clac_pkg::TICKS_W-1:0]   cnt_wdata;
    logic [clac_pkg::TICKS_W-1:0]   cnt_rdata;
    logic [clac_pkg::TICKS_W-1:0]   cnt_dec;
    logic [IW-1:0]                  rd_addr;
    logic [3:0]                     len_c;
    logic                           uid_match;
    logic [clac_pkg::MASK_W-1:0]    relay_vis;

    assign rd_addr   = r_rd_idx[IW-1:0];
    assign len_c     = ({1'b0, i_uid_length} > 4'(UID_BYTES)) ? 4'(UID_BYTES)
                                                               : {1'b0, i_uid_length};
    assign uid_match = ((tbl_rdata ^ r_uid) & r_mask) == '0;
    assign cnt_dec   = cnt_rdata - {{(clac_pkg::TICKS_W-1){1'b0}}, (cnt_rdata != '0)};

    for (genvar g = 0; g < clac_pkg::MASK_W; g++) begin : g_vis
        if (g < LOCKERS) begin : g_on
            assign relay_vis[g] = n_relay[g];
        end else begin : g_off
            assign relay_vis[g] = 1'b0;
        end
    end

    clac_ram #(.WIDTH(clac_pkg::UID_W), .DEPTH(LOCKERS)) u_tbl (
        .i_clk   (i_clk),
        .i_we    (tbl_we),
        .i_waddr (tbl_waddr),
        .i_wdata (tbl_wdata),
        .i_raddr (rd_addr),
        .o_rdata (tbl_rdata)
    );

    clac_ram #(.WIDTH(clac_pkg::TICKS_W), .DEPTH(LOCKERS)) u_cnt (
        .i_clk   (i_clk),
        .i_we    (cnt_we),
        .i_waddr (cnt_waddr),
        .i_wdata (cnt_wdata),
        .i_raddr (rd_addr),
        .o_rdata (cnt_rdata)
    );

    always_comb begin
        n_state      = r_state;
        n_valid      = r_valid;
        n_relay      = r_relay;
        n_was        = r_was;
        n_open_ticks = i_cfg_we ? i_cfg_wdata : r_open_ticks;
        n_rd_idx     = r_rd_idx;
        n_cmp_vld    = r_cmp_vld;
        n_cmp_idx    = r_cmp_idx;
        n_uid        = r_uid;
        n_mask       = r_mask;
        n_evt        = r_evt;
        n_hit        = r_hit;
        n_hit_idx    = r_hit_idx;
        n_out_vld    = r_out_vld;
        n_out_mask   = r_out_mask;
        n_out_evt    = r_out_evt;
        n_out_hit    = r_out_hit;
        n_out_idx    = r_out_idx;
        tbl_we       = 1'b0;
        tbl_waddr    = IW'(i_entry_index);
        tbl_wdata    = i_entry_uid & clac_pkg::byte_mask(4'(UID_BYTES));
        cnt_we       = 1'b0;
        cnt_waddr    = r_cmp_idx;
        cnt_wdata    = r_open_ticks;

        if (r_out_vld && !i_out_stall) begin
            n_out_vld = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_evt     = clac_pkg::EVT_NONE;
                    n_hit     = 1'b0;
                    n_hit_idx = '0;
                    n_rd_idx  = '0;
                    n_cmp_vld = 1'b0;
                    n_state   = S_DONE;
                    case (i_kind)
                        clac_pkg::KIND_TICK: begin
                            n_state = S_TICK;
                        end
                        clac_pkg::KIND_POLL: begin
                            n_was = i_card_present;
                            if (i_card_present && !r_was) begin
                                n_evt   = clac_pkg::EVT_ARRIVE;
                                n_uid   = i_card_uid;
                                n_mask  = clac_pkg::byte_mask(len_c);
                                n_state = S_SCAN;
                            end else if (!i_card_present && r_was) begin
                                n_evt = clac_pkg::EVT_REMOVE;
                            end
                        end
                        clac_pkg::KIND_WRITE: begin
                            if (int'(i_entry_index) < LOCKERS) begin
                                tbl_we                = 1'b1;
                                n_valid[tbl_waddr]    = 1'b1;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_SCAN, S_TICK: begin
                if (r_rd_idx < CW'(LOCKERS)) begin
                    n_rd_idx  = r_rd_idx + CW'(1);
                    n_cmp_vld = 1'b1;
                    n_cmp_idx = rd_addr;
                end else begin
                    n_cmp_vld = 1'b0;
                end
                if (r_cmp_vld) begin
                    if (r_cmp_idx == IW'(LOCKERS - 1)) begin
                        n_state = S_DONE;
                    end
                    if (r_state == S_SCAN) begin
                        if (r_valid[r_cmp_idx] && uid_match) begin
                            n_hit              = 1'b1;
                            n_hit_idx          = r_cmp_idx;
                            cnt_we             = 1'b1;
                            n_relay[r_cmp_idx] = 1'b1;
                            n_state            = S_DONE;
                        end
                    end else if (r_relay[r_cmp_idx]) begin
                        cnt_we    = 1'b1;
                        cnt_wdata = cnt_dec;
                        if (cnt_dec == '0) begin
                            n_relay[r_cmp_idx] = 1'b0;
                        end
                    end
                end
            end
            S_DONE: begin
                if (!r_out_vld || !i_out_stall) begin
                    n_out_vld  = 1'b1;
                    n_out_mask = relay_vis;
                    n_out_evt  = r_evt;
                    n_out_hit  = r_hit;
                    n_out_idx  = r_hit ? clac_pkg::LIDX_W'(r_hit_idx) : '0;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_valid      <= '0;
            r_relay      <= '0;
            r_was        <= 1'b0;
            r_open_ticks <= clac_pkg::OPEN_TICKS_RST;
            r_cmp_vld    <= 1'b0;
            r_out_vld    <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_valid      <= n_valid;
            r_relay      <= n_relay;
            r_was        <= n_was;
            r_open_ticks <= n_open_ticks;
            r_cmp_vld    <= n_cmp_vld;
            r_out_vld    <= n_out_vld;
        end
        r_rd_idx   <= n_rd_idx;
        r_cmp_idx  <= n_cmp_idx;
        r_uid      <= n_uid;
        r_mask     <= n_mask;
        r_evt      <= n_evt;
        r_hit      <= n_hit;
        r_hit_idx  <= n_hit_idx;
        r_out_mask <= n_out_mask;
        r_out_evt  <= n_out_evt;
        r_out_hit  <= n_out_hit;
        r_out_idx  <= n_out_idx;
    end

    assign o_in_stall     = (r_state != S_IDLE);
    assign o_out_valid    = r_out_vld;
    assign o_relay_mask   = r_out_mask;
    assign o_card_event   = r_out_evt;
    assign o_matched      = r_out_hit;
    assign o_locker_index = r_out_idx;

endmodule

// ===== rtl/clac_checker.sv =====
// Port-level checker for the card locker access controller core, with its bind.
// Depends on clac_pkg; attaches to card_locker_access_controller_core.
`timescale 1ns / 1ps

module clac_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_in_valid,
    input logic                         o_in_stall,
    input logic                         o_out_valid,
    input logic                         i_out_stall,
    input logic [clac_pkg::MASK_W-1:0]  o_relay_mask,
    input logic [clac_pkg::EVT_W-1:0]   o_card_event,
    input logic                         o_matched,
    input logic [clac_pkg::LIDX_W-1:0]  o_locker_index
);

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_relay_mask)
            && $stable(o_card_event) && $stable(o_matched) && $stable(o_locker_index))
        else $error("result changed while stalled");

    // one item in flight: input side stalls after each transfer
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input not stalled after transfer");

    a_idx_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_matched |-> o_locker_index == '0)
        else $error("locker index without match");

    a_match_arrive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_matched |-> o_card_event == clac_pkg::EVT_ARRIVE)
        else $error("match reported without arriving card");

endmodule

bind card_locker_access_controller_core clac_checker u_clac_checker (.*);

// ===== dv/tb_top.sv =====
// Self-checking testbench for card_locker_access_controller_core: random and directed
// table writes, reader polls and ticks, checked against a behavioural model in a scoreboard.
// Depends on clac_pkg and the core RTL (with its RAM).
`timescale 1ns / 1ps

module tb_top;

    import clac_pkg::*;

    localparam int LOCKERS      = LOCKERS_DEF;
    localparam int UID_BYTES    = UID_BYTES_DEF;
    localparam int WATCHDOG     = 2000;
    localparam int DRAIN_CYCLES = LOCKERS + 8;
    localparam int MAX_REPORTS  = 200;

    localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;

    typedef logic [KIND_W-1:0]  kind_t;
    typedef logic [UID_W-1:0]   uid_t;
    typedef logic [LEN_W-1:0]   len_t;
    typedef logic [EIDX_W-1:0]  eidx_t;
    typedef logic [MASK_W-1:0]  mask_t;
    typedef logic [TICKS_W-1:0] ticks_t;
    typedef logic [EVT_W-1:0]   evt_t;
    typedef logic [LIDX_W-1:0]  lidx_t;

    typedef struct packed {
        kind_t kind;
        logic  present;
        uid_t  card_uid;
        len_t  uid_len;
        eidx_t entry_index;
        uid_t  entry_uid;
    } item_t;

    typedef struct packed {
        mask_t relay_mask;
        evt_t  card_event;
        logic  matched;
        lidx_t locker_index;
    } result_t;

    localparam uid_t UID_A = 56'h11_2233_4455_6677;
    localparam uid_t UID_B = 56'h80_0102_0304_0506;
    localparam uid_t UID_C = 56'h5A_A55A_A55A_A55A;
    localparam uid_t UID_D = 56'hAA_BBCC_DD55_6677;

    class locker_scoreboard;
        uid_t    tbl_uid[LOCKERS];
        bit      tbl_valid[LOCKERS];
        mask_t   relay;
        ticks_t  remain[LOCKERS];
        bit      card_seen;
        ticks_t  open_ticks;
        result_t due[$];
        int      fails;

        function new();
            for (int i = 0; i < LOCKERS; i++) begin
                tbl_uid[i]   = '0;
                tbl_valid[i] = 1'b0;
                remain[i]    = '0;
            end
            relay      = '0;
            card_seen  = 1'b0;
            open_ticks = OPEN_TICKS_RST;
            fails      = 0;
        endfunction

        static function uid_t cmp_mask(int n);
            uid_t m;
            m = '0;
            for (int b = 0; b < UID_W / 8; b++) begin
                if (b < n) begin
                    m[b*8 +: 8] = 8'hFF;
                end
            end
            return m;
        endfunction

        function void note_transfer(item_t it);
            result_t r;
            uid_t    m;
            int      n;
            r = '0;
            case (it.kind)
                KIND_TICK: begin
                    for (int i = 0; i < LOCKERS; i++) begin
                        if (relay[i]) begin
                            if (remain[i] != 0) begin
                                remain[i] = remain[i] - 1'b1;
                            end
                            if (remain[i] == 0) begin
                                relay[i] = 1'b0;
                            end
                        end
                    end
                end
                KIND_POLL: begin
                    if (it.present && !card_seen) begin
                        r.card_event = EVT_ARRIVE;
                        n = (it.uid_len > UID_BYTES) ? UID_BYTES : int'(it.uid_len);
                        m = cmp_mask(n);
                        for (int i = 0; i < LOCKERS; i++) begin
                            if (!r.matched && tbl_valid[i]
                                    && ((tbl_uid[i] ^ it.card_uid) & m) == '0) begin
                                r.matched      = 1'b1;
                                r.locker_index = lidx_t'(i);
                                relay[i]       = 1'b1;
                                remain[i]      = open_ticks;
                            end
                        end
                    end else if (!it.present && card_seen) begin
                        r.card_event = EVT_REMOVE;
                    end
                    card_seen = it.present;
                end
                KIND_WRITE: begin
                    if (it.entry_index < LOCKERS) begin
                        tbl_uid[it.entry_index]   = it.entry_uid;
                        tbl_valid[it.entry_index] = 1'b1;
                    end
                end
                default: begin
                end
            endcase
            r.relay_mask = relay;
            due.push_back(r);
        endfunction

        function void report(string what, longint unsigned exp_v, longint unsigned act_v);
            fails++;
            if (fails <= MAX_REPORTS) begin
                $display("%0t: %s mismatch, expected %0h actual %0h", $time, what, exp_v, act_v);
            end
        endfunction

        function void check_result(result_t got);
            result_t exp_r;
            if (due.size() == 0) begin
                report("unexpected result, relay_mask", 0, got.relay_mask);
                return;
            end
            exp_r = due.pop_front();
            if (got.relay_mask !== exp_r.relay_mask) begin
                report("relay_mask", exp_r.relay_mask, got.relay_mask);
            end
            if (got.card_event !== exp_r.card_event) begin
                report("card_event", exp_r.card_event, got.card_event);
            end
            if (got.matched !== exp_r.matched) begin
                report("matched", exp_r.matched, got.matched);
            end
            if (got.locker_index !== exp_r.locker_index) begin
                report("locker_index", exp_r.locker_index, got.locker_index);
            end
        endfunction

        function int pending();
            return due.size();
        endfunction
    endclass

    logic   i_clk = 1'b0;
    logic   i_rst_n;
    logic   i_cfg_we;
    ticks_t i_cfg_wdata;
    logic   i_in_valid;
    logic   o_in_stall;
    kind_t  i_kind;
    logic   i_card_present;
    uid_t   i_card_uid;
    len_t   i_uid_length;
    eidx_t  i_entry_index;
    uid_t   i_entry_uid;
    logic   o_out_valid;
    logic   i_out_stall;
    mask_t  o_relay_mask;
    evt_t   o_card_event;
    logic   o_matched;
    lidx_t  o_locker_index;

    locker_scoreboard sb;
    int src_idle_pct = 36;
    int dst_idle_pct = 50;
    int quiet_cycles = 0;

    card_locker_access_controller_core DUT (.*);

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < dst_idle_pct);
    end

    // result check and watchdog
    always @(posedge i_clk) begin
        if (i_rst_n !== 1'b1) begin
            quiet_cycles = 0;
        end else begin
            if (o_out_valid === 1'b1 && i_out_stall === 1'b0) begin
                sb.check_result('{relay_mask: o_relay_mask, card_event: o_card_event,
                                  matched: o_matched, locker_index: o_locker_index});
                quiet_cycles = 0;
            end else if (i_in_valid && o_in_stall === 1'b0) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= WATCHDOG) begin
                $display("card_locker_access_controller_core test failed");
                $finish;
            end
        end
    end

    function automatic uid_t rand_uid();
        return uid_t'({$urandom, $urandom});
    endfunction

    function automatic item_t mk(kind_t k, logic p, uid_t u, len_t l, eidx_t e, uid_t eu);
        item_t it;
        it.kind        = k;
        it.present     = p;
        it.card_uid    = u;
        it.uid_len     = l;
        it.entry_index = e;
        it.entry_uid   = eu;
        return it;
    endfunction

    // mostly well-formed traffic: presented cards often carry a stored identifier
    function automatic item_t gen_item();
        item_t it;
        int    r;
        int    live[$];
        uid_t  m;
        it = mk(kind_t'($urandom_range(3)), 1'($urandom_range(1)), rand_uid(),
                len_t'($urandom_range(7)), eidx_t'($urandom_range(15)), rand_uid());
        for (int i = 0; i < LOCKERS; i++) begin
            if (sb.tbl_valid[i]) begin
                live.push_back(i);
            end
        end
        r = $urandom_range(99);
        if (r < 35) begin
            it.kind = KIND_TICK;
        end else if (r < 75) begin
            it.kind = KIND_POLL;
            it.present = sb.card_seen ? ($urandom_range(99) < 20) : ($urandom_range(99) < 80);
            if (live.size() > 0 && $urandom_range(99) < 70) begin
                m = locker_scoreboard::cmp_mask(it.uid_len);
                it.card_uid = (sb.tbl_uid[live[$urandom_range(live.size() - 1)]] & m)
                            | (it.card_uid & ~m);
            end
        end else if (r < 95) begin
            it.kind = KIND_WRITE;
            case ($urandom_range(7))
                0: begin
                    it.entry_uid = '0;
                end
                1: begin
                    it.entry_uid = '1;
                end
                2, 3: begin
                    if (live.size() > 0) begin
                        it.entry_uid = sb.tbl_uid[live[$urandom_range(live.size() - 1)]];
                    end
                end
                default: begin
                end
            endcase
        end else begin
            it.kind = KIND_SPARE;
        end
        return it;
    endfunction

    task automatic send_item(input item_t it);
        while ($urandom_range(99) < src_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_kind         <= it.kind;
        i_card_present <= it.present;
        i_card_uid     <= it.card_uid;
        i_uid_length   <= it.uid_len;
        i_entry_index  <= it.entry_index;
        i_entry_uid    <= it.entry_uid;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        sb.note_transfer(it);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_open_ticks(input ticks_t v);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we      <= 1'b0;
        sb.open_ticks = v;
    endtask

    task automatic run_random(input int n);
        repeat (n) send_item(gen_item());
    endtask

    initial begin
        item_t plan[$];
        sb = new();
        i_rst_n        <= 1'b0;
        i_cfg_we       <= 1'b0;
        i_cfg_wdata    <= '0;
        i_in_valid     <= 1'b0;
        i_kind         <= KIND_TICK;
        i_card_present <= 1'b0;
        i_card_uid     <= '0;
        i_uid_length   <= '0;
        i_entry_index  <= '0;
        i_entry_uid    <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty table, edges of presence, duplicates, short and zero lengths
        plan.push_back(mk(KIND_POLL,  1'b1, '1,    3'd7, 4'd0,  '0));
        plan.push_back(mk(KIND_POLL,  1'b1, '0,    3'd0, 4'd0,  '0));
        plan.push_back(mk(KIND_POLL,  1'b0, '0,    3'd0, 4'd0,  '0));
        plan.push_back(mk(KIND_POLL,  1'b0, '1,    3'd7, 4'd15, '1));
        plan.push_back(mk(KIND_WRITE, 1'b0, '1,    3'd7, 4'd0,  '0));
        plan.push_back(mk(KIND_WRITE, 1'b1, '0,    3'd0, 4'd15, '1));
        plan.push_back(mk(KIND_WRITE, 1'b0, '0,    3'd0, 4'd5,  UID_A));
        plan.push_back(mk(KIND_WRITE, 1'b0, '0,    3'd0, 4'd9,  UID_A));
        plan.push_back(mk(KIND_POLL,  1'b1, UID_A, 3'd7, 4'd0,  '0));
        plan.push_back(mk(KIND_POLL,  1'b0, UID_A, 3'd7, 4'd0,  '0));
        plan.push_back(mk(KIND_POLL,  1'b1, '1,    3'd7, 4'd0,  '0));
        plan.push_back(mk(KIND_POLL,  1'b0, '1,    3'd7, 4'd0,  '0));
        plan.push_back(mk(KIND_POLL,  1'b1, UID_C, 3'd0, 4'd0,  '0));
        plan.push_back(mk(KIND_POLL,  1'b0, UID_C, 3'd0, 4'd0,  '0));
        plan.push_back(mk(KIND_POLL,  1'b1, UID_D, 3'd3, 4'd0,  '0));
        plan.push_back(mk(KIND_SPARE, 1'b0, UID_C, 3'd5, 4'd7,  UID_C));
        plan.push_back(mk(KIND_TICK,  1'b1, '1,    3'd7, 4'd15, '1));
        plan.push_back(mk(KIND_TICK,  1'b0, '0,    3'd0, 4'd0,  '0));
        plan.push_back(mk(KIND_POLL,  1'b0, UID_D, 3'd3, 4'd0,  '0));
        plan.push_back(mk(KIND_WRITE, 1'b0, '0,    3'd0, 4'd5,  UID_B));
        plan.push_back(mk(KIND_POLL,  1'b1, UID_A, 3'd7, 4'd0,  '0));
        plan.push_back(mk(KIND_POLL,  1'b0, UID_A, 3'd7, 4'd0,  '0));
        plan.push_back(mk(KIND_TICK,  1'b0, '0,    3'd0, 4'd0,  '0));
        foreach (plan[i]) begin
            send_item(plan[i]);
        end

        set_open_ticks(16'd1);
        run_random(200);

        src_idle_pct = 50;
        dst_idle_pct = 36;
        set_open_ticks(16'hFFFF);
        run_random(200);

        src_idle_pct = 0;
        dst_idle_pct = 0;
        set_open_ticks(ticks_t'(2 * $urandom_range(1, 20)));
        run_random(200);

        drain();
        if (sb.fails == 0 && sb.pending() == 0) begin
            $display("card_locker_access_controller_core test passed");
        end else begin
            $display("card_locker_access_controller_core test failed");
        end
        $finish;
    end

endmodule
